### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// Stack with search package
// Command and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_OUT_W = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN,
    S_RESULT
  } state_t;

endpackage

### hw/rtl/stack_with_search_top.sv
// A push result is registered from S_RESULT after its transfer, a pop result
// after S_POP_WAIT and S_RESULT, and a search result after S_SCAN has compared
// k entries (1 to the count held) and S_RESULT; the single comparator checks
// one stored word per cycle. Items are taken one at a time; the next transfer
// is taken the cycle after the result is registered (which waits while an
// earlier result is still held). Reset: synchronous, active high; empties the
// stack, storage is not cleared.
// ----------------------------------------------------------------------------
// Stack with search, top level
// LIFO stack of signed 32-bit words with push, pop and top-down search.
// ----------------------------------------------------------------------------
module stack_with_search_top import sws_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic signed [WORD_W-1:0]    value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic signed [WORD_W-1:0]    popped_value,
  output logic [CNT_OUT_W-1:0]        position,
  output logic [CNT_OUT_W-1:0]        occupancy
);

`include "assert_macros.svh"

  // Address width covers DEPTH entries; the count must also hold DEPTH itself.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  // The sequencer owns the entry count, the search index and the result
  // register. Search walks down from the top of the stack, reading one word a
  // cycle from the RAM and comparing it against the key in the single
  // comparator; the first hit ends the walk.
  sws_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .popped_value (popped_value),
    .position     (position),
    .occupancy    (occupancy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  // Stack words live in a single RAM; only words read from entries below the
  // count are used, and each of those was written by an earlier push.
  sws_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // in_ready is low in the cycle after every input transfer.
  `ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  // Only a successful pop carries a word, and it never carries a position.
  `ASSERT_IMPL(a_popped_only_ok, out_valid && popped_value != '0, status == STAT_OK && position == '0)
  // An empty report means nothing is held.
  `ASSERT_IMPL(a_empty_count, out_valid && status == STAT_EMPTY, occupancy == '0)
  // A full report means DEPTH entries are held.
  `ASSERT_IMPL(a_full_count, out_valid && status == STAT_FULL, occupancy == CNT_OUT_W'(DEPTH))

endmodule

### hw/rtl/sws_mem.sv
// ----------------------------------------------------------------------------
// Stack storage
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sws_mem import sws_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// Stack sequencer
// Runs push and pop, and the top-down search through the single word comparator,
// and holds the result register.
// ----------------------------------------------------------------------------
module sws_ctrl import sws_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = 8,
  parameter int unsigned CW = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic signed [WORD_W-1:0]    value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic signed [WORD_W-1:0]    popped_value,
  output logic [CNT_OUT_W-1:0]        position,
  output logic [CNT_OUT_W-1:0]        occupancy,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [WORD_W-1:0]           wr_data,
  output logic [AW-1:0]               rd_addr,
  input  logic [WORD_W-1:0]           rd_data
);

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [AW-1:0]          idx, idx_next;
  logic [WORD_W-1:0]      key, key_next;
  logic [1:0]             res_status, res_status_next;
  logic [WORD_W-1:0]      res_popped, res_popped_next;
  logic [CNT_OUT_W-1:0]   res_pos, res_pos_next;
  logic                   load_out;
  logic                   full;
  logic                   empty;
  logic                   hit;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign hit   = (rd_data == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_popped <= res_popped_next;
    res_pos    <= res_pos_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    key_next        = key;
    res_status_next = res_status;
    res_popped_next = res_popped;
    res_pos_next    = res_pos;
    wr_en           = 1'b0;
    wr_addr         = count[AW-1:0];
    wr_data         = value;
    rd_addr         = AW'(count - 1'b1);
    in_ready        = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_next        = value;
          res_status_next = STAT_OK;
          res_popped_next = '0;
          res_pos_next    = '0;
          state_next      = S_RESULT;
          unique case (command)
            CMD_PUSH: begin
              if (full) begin
                res_status_next = STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                res_status_next = STAT_EMPTY;
              end else begin
                count_next = count - 1'b1;
                state_next = S_POP_WAIT;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                res_status_next = STAT_EMPTY;
              end else begin
                idx_next   = AW'(count - 1'b1);
                state_next = S_SCAN;
              end
            end
            default: begin
              res_status_next = STAT_OK;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        res_popped_next = rd_data;
        state_next      = S_RESULT;
      end
      S_SCAN: begin
        // Prefetch the entry below while the current one is compared.
        rd_addr = idx - 1'b1;
        if (hit) begin
          res_pos_next = CNT_OUT_W'(count - CW'(idx));
          state_next   = S_RESULT;
        end else if (idx == '0) begin
          res_status_next = STAT_MISSING;
          state_next      = S_RESULT;
        end else begin
          idx_next = idx - 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= res_status;
      popped_value <= res_popped;
      position     <= res_pos;
      occupancy    <= CNT_OUT_W'(count);
    end
  end

endmodule

### bench/tb_stack_with_search_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack with search testbench
// Drives push, pop, search and unused commands through the valid/ready input
// channel. A behavioral copy of the stack in this file predicts every result,
// and each result transfer is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_stack_with_search_top;
  import sws_pkg::*;

  localparam int STACK_DEPTH = 256;

  // The package names three commands; the fourth code must act as a no-op.
  localparam logic [1:0] CMD_NOOP = 2'd3;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  // Pushed first in the fill phase so that a search can hit the bottom entry.
  localparam logic signed [WORD_W-1:0] BOTTOM_MARK = 32'sh5A5A_C3C3;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [WORD_W-1:0]    popped;
    logic [CNT_OUT_W-1:0]        position;
    logic [CNT_OUT_W-1:0]        occupancy;
  } stack_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  command = CMD_PUSH;
  logic signed [WORD_W-1:0]    value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  status;
  logic signed [WORD_W-1:0]    popped_value;
  logic [CNT_OUT_W-1:0]        position;
  logic [CNT_OUT_W-1:0]        occupancy;

  // Behavioral copy of the stack. Index 0 is the bottom entry.
  logic signed [WORD_W-1:0]    stack_words [STACK_DEPTH];
  int                          stack_count = 0;

  // Results predicted at each input transfer, oldest first.
  stack_result_t               pending_results [$];
  stack_result_t               head_result;
  int                          error_count = 0;

  // Random idling is switched per phase so that some stretches run at full rate.
  bit                          sender_idle = 1'b1;
  bit                          receiver_idle = 1'b1;

  stack_with_search_top #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .popped_value(popped_value),
    .position(position),
    .occupancy(occupancy)
  );

  always #10 clk = ~clk;

  // Applies one command to the behavioral stack and returns the result that
  // the block must produce for it. The search walks from the top entry down,
  // so the first equal word found is the one nearest the top.
  function automatic stack_result_t apply_command(input logic [1:0] cmd,
                                                  input logic signed [WORD_W-1:0] word);
    stack_result_t r;
    int            idx;
    r = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_PUSH: begin
        if (stack_count >= STACK_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          stack_words[stack_count] = word;
          stack_count++;
        end
      end
      CMD_POP: begin
        if (stack_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          stack_count--;
          r.popped = stack_words[stack_count];
        end
      end
      CMD_SEARCH: begin
        if (stack_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status = STAT_MISSING;
          for (idx = stack_count - 1; idx >= 0; idx--) begin
            if (stack_words[idx] == word) begin
              r.status = STAT_OK;
              r.position = CNT_OUT_W'(stack_count - idx);
              break;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = CNT_OUT_W'(stack_count);
    return r;
  endfunction

  // Words are drawn from several pools: fully random words exercise every
  // bit, small and extreme values make repeats, and so duplicate matches, likely.
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $urandom_range(0, 15);
      3: return -($urandom_range(1, 16));
      default: begin
        case ($urandom_range(0, 3))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Most searches look for a word that is held somewhere in the stack, so
  // that hits occur at every depth; the rest are likely to miss.
  function automatic logic signed [WORD_W-1:0] search_word();
    if (stack_count > 0 && $urandom_range(0, 2) != 0) begin
      return stack_words[$urandom_range(0, stack_count - 1)];
    end
    return random_word();
  endfunction

  // Sends one command. The task is entered and left at a rising edge; it
  // leaves in_valid high after the transfer so that a following call can
  // present the next item at once. The prediction is made at the transfer.
  task automatic send_item(input logic [1:0] cmd, input logic signed [WORD_W-1:0] word);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= word;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_results.push_back(apply_command(cmd, word));
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Pop, search and the unused code on an empty stack: pop and search report
  // empty, and the unused code does nothing.
  task automatic test_empty_stack();
    send_item(CMD_POP, random_word());
    send_item(CMD_SEARCH, '0);
    send_item(CMD_SEARCH, WORD_MIN);
    send_item(CMD_NOOP, $urandom);
  endtask

  // Extreme words, a duplicated top entry, hits at several depths, a miss,
  // the unused code on a non-empty stack, then pops down past empty.
  task automatic test_field_extremes();
    send_item(CMD_PUSH, WORD_MIN);
    send_item(CMD_PUSH, WORD_MAX);
    send_item(CMD_PUSH, '0);
    send_item(CMD_PUSH, -1);
    send_item(CMD_PUSH, -1);
    send_item(CMD_SEARCH, -1);
    send_item(CMD_SEARCH, WORD_MIN);
    send_item(CMD_SEARCH, '0);
    send_item(CMD_SEARCH, WORD_MAX);
    send_item(CMD_SEARCH, 32'sd12345);
    send_item(CMD_NOOP, -1);
    repeat (6) send_item(CMD_POP, '0);
    send_item(CMD_SEARCH, -1);
  endtask

  // Fills the stack with random words over a unique bottom entry, pushes
  // into the full stack, searches the whole depth, and empties it again.
  task automatic test_fill_and_drain();
    send_item(CMD_PUSH, BOTTOM_MARK);
    while (stack_count < STACK_DEPTH) send_item(CMD_PUSH, random_word());
    send_item(CMD_PUSH, random_word());
    send_item(CMD_PUSH, WORD_MAX);
    send_item(CMD_SEARCH, BOTTOM_MARK);
    repeat (5) send_item(CMD_SEARCH, search_word());
    send_item(CMD_SEARCH, $urandom);
    send_item(CMD_NOOP, $urandom);
    while (stack_count > 0) send_item(CMD_POP, random_word());
    send_item(CMD_POP, random_word());
  endtask

  // Random command mix. Pushes are favored while the stack is shallow and
  // pops once it is deeper, so the count wanders without drifting to full.
  task automatic test_random_traffic(input int n_items, input bit s_idle, input bit r_idle);
    int roll;
    int push_pct;
    sender_idle = s_idle;
    receiver_idle = r_idle;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      push_pct = (stack_count < 40) ? 48 : 34;
      if (roll < push_pct) begin
        send_item(CMD_PUSH, random_word());
      end else if (roll < 72) begin
        send_item(CMD_POP, random_word());
      end else if (roll < 96) begin
        send_item(CMD_SEARCH, search_word());
      end else begin
        send_item(CMD_NOOP, random_word());
      end
    end
  endtask

  // Result side: out_ready is low in random bursts while receiver_idle is set.
  initial begin
    forever begin
      @(posedge clk);
      if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none predicted, status %0d occupancy %0d",
                 $time, status, occupancy);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", WORD_W'(head_result.status), WORD_W'(status));
        check_field("popped_value", head_result.popped, popped_value);
        check_field("position", WORD_W'(head_result.position), WORD_W'(position));
        check_field("occupancy", WORD_W'(head_result.occupancy), WORD_W'(occupancy));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_field_extremes();
    // The sender holds off here until the block has returned everything.
    wait_for_results();
    test_fill_and_drain();
    wait_for_results();
    test_random_traffic(400, 1'b1, 1'b1);
    test_random_traffic(300, 1'b0, 1'b0);
    test_random_traffic(300, 1'b1, 1'b0);
    test_random_traffic(300, 1'b0, 1'b1);
    // The closing stretch runs with no idling on either side.
    test_random_traffic(300, 1'b0, 1'b0);
    wait_for_results();
    // A deep search compares up to DEPTH entries, so this wait covers any
    // stray result that might still follow.
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("stack_with_search_top: match");
    end else begin
      $display("stack_with_search_top: mismatch");
    end
    $finish;
  end

  // Run limit: several times the slowest legal run, where every item is a
  // full-depth search with the longest gaps and stalls on both sides.
  initial begin
    #50_000_000;
    $display("stack_with_search_top: mismatch");
    $finish;
  end

endmodule
